>>> hdl/ldce_pkg.sv
package ldce_pkg;

  localparam int UnitCountDefault = 15;
  localparam int CordicSteps = 16;
  localparam logic [16:0] DemandReset = 17'd42080;
  localparam logic [20:0] CostMax = 21'h1FFFFF;
  localparam logic [16:0] PowerMax = 17'h1FFFF;
  localparam logic [9:0] ExcessMax = 10'h3FF;
  localparam logic [2:0] HitsMax = 3'h7;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic [9:0] a;
    logic [11:0] b;
    logic [14:0] c;
    logic [8:0] d;
    logic [9:0] e;
    logic [7:0] pmin;
  } coef_t;

  typedef struct packed {
    logic [20:0] cost;
    logic [16:0] pwr;
    logic [9:0] excess;
    logic hit;
  } unit_sum_t;

  function automatic logic [63:0] coef_word(input logic [3:0] u);
    case (u)
      4'd0: coef_word = {10'd671, 12'd2586, 15'd1254, 9'd100, 10'd876, 8'd150};
      4'd1: coef_word = {10'd574, 12'd2611, 15'd768, 9'd100, 10'd876, 8'd150};
      4'd2: coef_word = {10'd374, 12'd2253, 15'd4723, 9'd100, 10'd876, 8'd20};
      4'd3: coef_word = {10'd374, 12'd2253, 15'd4723, 9'd150, 10'd657, 8'd20};
      4'd4: coef_word = {10'd461, 12'd2662, 15'd860, 9'd120, 10'd803, 8'd150};
      4'd5: coef_word = {10'd630, 12'd2586, 15'd1262, 9'd100, 10'd876, 8'd135};
      4'd6: coef_word = {10'd548, 12'd2509, 15'd1527, 9'd200, 10'd438, 8'd135};
      4'd7: coef_word = {10'd227, 12'd2867, 15'd1418, 9'd200, 10'd438, 8'd60};
      4'd8: coef_word = {10'd173, 12'd2867, 15'd3385, 9'd200, 10'd438, 8'd25};
      4'd9: coef_word = {10'd175, 12'd2739, 15'd5046, 9'd200, 10'd438, 8'd25};
      4'd10: coef_word = {10'd186, 12'd2611, 15'd15041, 9'd200, 10'd438, 8'd20};
      4'd11: coef_word = {10'd230, 12'd2534, 15'd23123, 9'd200, 10'd438, 8'd20};
      4'd12: coef_word = {10'd225, 12'd3354, 15'd1556, 9'd300, 10'd365, 8'd25};
      4'd13: coef_word = {10'd309, 12'd3098, 15'd8091, 9'd300, 10'd365, 8'd15};
      4'd14: coef_word = {10'd323, 12'd3174, 15'd18652, 9'd300, 10'd365, 8'd15};
      default: coef_word = 64'd0;
    endcase
  endfunction

  // Zone pairs as {h2,l2,h1,l1,h0,l0}, ten bits each.
  function automatic logic [59:0] zone_word(input logic [3:0] u);
    case (u)
      4'd1: zone_word = {10'd450, 10'd420, 10'd335, 10'd305, 10'd225, 10'd185};
      4'd4: zone_word = {10'd420, 10'd390, 10'd335, 10'd305, 10'd200, 10'd180};
      4'd5: zone_word = {10'd455, 10'd430, 10'd395, 10'd365, 10'd230, 10'd225};
      4'd11: zone_word = {10'd0, 10'd0, 10'd65, 10'd55, 10'd40, 10'd30};
      default: zone_word = 60'd0;
    endcase
  endfunction

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0: atan_turn = 32'd536870912;
      4'd1: atan_turn = 32'd316933406;
      4'd2: atan_turn = 32'd167458907;
      4'd3: atan_turn = 32'd85004756;
      4'd4: atan_turn = 32'd42667331;
      4'd5: atan_turn = 32'd21354465;
      4'd6: atan_turn = 32'd10679838;
      4'd7: atan_turn = 32'd5340245;
      4'd8: atan_turn = 32'd2670163;
      4'd9: atan_turn = 32'd1335087;
      4'd10: atan_turn = 32'd667544;
      4'd11: atan_turn = 32'd333772;
      4'd12: atan_turn = 32'd166886;
      4'd13: atan_turn = 32'd83443;
      4'd14: atan_turn = 32'd41722;
      default: atan_turn = 32'd20861;
    endcase
  endfunction

endpackage

>>> hdl/ldce_in_if.sv
interface ldce_in_if;
  logic valid;
  logic ready;
  logic [12:0] power;
  logic [3:0] unit_index;
  logic last_unit;
  modport source (output valid, power, unit_index, last_unit, input ready);
  modport sink (input valid, power, unit_index, last_unit, output ready);
endinterface

>>> hdl/ldce_out_if.sv
interface ldce_out_if;
  logic valid;
  logic ready;
  logic [20:0] cost_total;
  logic [16:0] balance_error;
  logic [9:0] zone_excess;
  logic [2:0] zone_hits;
  modport source (output valid, cost_total, balance_error, zone_excess, zone_hits,
                  input ready);
  modport sink (input valid, cost_total, balance_error, zone_excess, zone_hits,
                output ready);
endinterface

>>> hdl/load_dispatch_cost_evaluator_unit.sv
// The dispatch result is valid once the last unit has passed the phase multiply, the
// CORDIC (load and 16 micro-rotations), then b, p*p, c and d through the shared
// multiplier. One item at a time; after a last unit the input waits until the dispatch
// result has been taken.
// Synchronous reset clears the sums and sets the demand register to 42080.
module load_dispatch_cost_evaluator_unit import ldce_pkg::*; #(
  parameter int UNIT_COUNT = UnitCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  ldce_in_if.sink     in_ch,
  ldce_out_if.source  out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PHASE = 7'b0000010, S_SINE = 7'b0000100,
    S_MB = 7'b0001000, S_MC1 = 7'b0010000, S_MC2 = 7'b0100000,
    S_MD = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [16:0] demand;
  logic [12:0] p;
  logic [3:0] u;
  logic last, inrange;
  coef_t cw;
  logic [59:0] zw;
  logic [31:0] phase;
  logic cstart, cdone;
  logic [15:0] sine;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [20:0] cost;
  logic [20:0] cost_d;
  logic [25:0] psq;
  unit_sum_t inc;
  logic add, clear;
  logic [20:0] cost_sum;
  logic [16:0] power_sum;
  logic [9:0] excess_sum;
  logic [2:0] hit_count;
  logic [13:0] lo, hi;
  logic found;

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid && !rst;
  assign cw = coef_t'(coef_word(u));
  assign zw = zone_word(u);

  // Shared multiplier, operands chosen by state.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_PHASE: begin
        ma = 32'(cw.e);
        mb = 32'({cw.pmin, 4'd0}) - 32'(p);
      end
      S_MB: begin
        ma = 32'(cw.b);
        mb = 32'(p);
      end
      S_MC1: begin
        ma = 32'(p);
        mb = 32'(p);
      end
      S_MC2: begin
        ma = 32'(cw.c);
        mb = 32'(psq);
      end
      S_MD: begin
        ma = 32'({cw.d, 4'd0});
        mb = 32'(sine);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  // The phase goes straight from the multiplier into the CORDIC as it starts.
  assign phase = {prod[19:0], 12'd0};

  ldce_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .phase(phase), .done(cdone), .sine(sine)
  );

  always_comb begin
    inc.excess = '0;
    inc.hit = 1'b0;
    found = 1'b0;
    lo = '0;
    hi = '0;
    for (int k = 0; k < 3; k++) begin
      lo = {zw[20*k +: 10], 4'd0};
      hi = {zw[20*k+10 +: 10], 4'd0};
      if (!found && {1'b0, p} > lo && {1'b0, p} < hi) begin
        found = 1'b1;
        inc.hit = 1'b1;
        inc.excess = (({1'b0, p} - lo) < (hi - {1'b0, p})) ?
                     10'({1'b0, p} - lo) : 10'(hi - {1'b0, p});
      end
    end
    cost_d = cost + 21'((prod + 64'd16384) >> 15);
    inc.cost = cost_d;
    inc.pwr = 17'(p);
  end

  assign add = (state == S_MD) && inrange;
  assign clear = (state == S_MD) && last;

  ldce_accum u_accum (
    .clk(clk), .rst(rst), .add(add), .clear(clear), .inc(inc),
    .cost_sum(cost_sum), .power_sum(power_sum), .excess_sum(excess_sum),
    .hit_count(hit_count)
  );

  // The last unit is folded in here, as the sums clear on the same edge.
  logic [21:0] fin_cost;
  logic [17:0] fin_pwr;
  logic [16:0] fin_psat;
  logic [16:0] fin_bal;
  logic [10:0] fin_exc;
  logic [2:0] fin_hit;
  always_comb begin
    fin_cost = {1'b0, cost_sum} + (inrange ? {1'b0, inc.cost} : 22'd0);
    fin_pwr = {1'b0, power_sum} + (inrange ? {5'd0, p} : 18'd0);
    fin_psat = fin_pwr[17] ? PowerMax : fin_pwr[16:0];
    fin_exc = {1'b0, excess_sum} + (inrange ? {1'b0, inc.excess} : 11'd0);
    fin_hit = (inrange && inc.hit && hit_count != HitsMax) ? hit_count + 3'd1 : hit_count;
    fin_bal = (fin_psat >= demand) ? fin_psat - demand : demand - fin_psat;
  end

  always_comb begin
    state_next = state;
    cstart = 1'b0;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_PHASE;
      S_PHASE: begin
        cstart = 1'b1;
        state_next = S_SINE;
      end
      S_SINE: if (cdone) state_next = S_MB;
      S_MB: state_next = S_MC1;
      S_MC1: state_next = S_MC2;
      S_MC2: state_next = S_MD;
      S_MD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      demand <= DemandReset;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) demand <= cfg_data;
      if (state == S_MD && last) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      p <= in_ch.power;
      u <= in_ch.unit_index;
      last <= in_ch.last_unit;
      inrange <= ({1'b0, in_ch.unit_index} < 5'(UNIT_COUNT));
      cost <= '0;
    end
    case (state)
      S_PHASE: cost <= 21'({cw.a, 4'd0});
      S_MB: cost <= cost + 21'((prod + 64'd128) >> 8);
      S_MC1: psq <= prod[25:0];
      S_MC2: cost <= cost + 21'((prod + 64'd33554432) >> 26);
      S_MD: cost <= cost_d;
      default: ;
    endcase
    if (state == S_MD && last) begin
      out_ch.cost_total <= fin_cost[21] ? CostMax : fin_cost[20:0];
      out_ch.balance_error <= fin_bal;
      out_ch.zone_excess <= fin_exc[10] ? ExcessMax : fin_exc[9:0];
      out_ch.zone_hits <= fin_hit;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cstart |=> state == S_SINE);
  assert property (@(posedge clk) disable iff (rst) cdone |-> state == S_SINE)
    else $error("CORDIC finished outside sine state");
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> state == S_PHASE)
    else $error("accepted item did not start");
endmodule

>>> hdl/ldce_cordic.sv
// Shift-and-add CORDIC rotation, one micro-rotation per cycle.
module ldce_cordic import ldce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] phase,
  output logic        done,
  output logic [15:0] sine
);
  logic signed [33:0] x, y, z;
  logic [3:0] step;
  logic busy;
  logic [30:0] ph;
  logic signed [33:0] xs, ys, yc;

  always_comb begin
    ph = phase[30:0];
    if (ph > 31'h40000000) begin
      ph = 31'h40000000 - (ph - 31'h40000000);
    end
    xs = x >>> step;
    ys = y >>> step;
    if (y < 0) begin
      yc = '0;
    end else if (y > 34'sh40000000) begin
      yc = 34'sh40000000;
    end else begin
      yc = y;
    end
    sine = 16'((yc + 34'sd16384) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= CordicGain;
        y <= '0;
        z <= 34'(ph);
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - 34'(atan_turn(step));
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + 34'(atan_turn(step));
        end
        step <= step + 4'd1;
        if (step == 4'(CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/ldce_accum.sv
// Saturating accumulators.
module ldce_accum import ldce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        add,
  input  logic        clear,
  input  unit_sum_t   inc,
  output logic [20:0] cost_sum,
  output logic [16:0] power_sum,
  output logic [9:0]  excess_sum,
  output logic [2:0]  hit_count
);
  logic [21:0] c_add;
  logic [17:0] p_add;
  logic [10:0] e_add;

  always_comb begin
    c_add = {1'b0, cost_sum} + {1'b0, inc.cost};
    p_add = {1'b0, power_sum} + {1'b0, inc.pwr};
    e_add = {1'b0, excess_sum} + {1'b0, inc.excess};
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cost_sum <= '0;
      power_sum <= '0;
      excess_sum <= '0;
      hit_count <= '0;
    end else if (add) begin
      cost_sum <= c_add[21] ? CostMax : c_add[20:0];
      power_sum <= p_add[17] ? PowerMax : p_add[16:0];
      excess_sum <= e_add[10] ? ExcessMax : e_add[9:0];
      if (inc.hit && hit_count != HitsMax) begin
        hit_count <= hit_count + 3'd1;
      end
    end
  end
endmodule
